// ===== src/sscd_pkg.sv =====
// Shared types and constants for the SPI slave command deframer.
// No dependencies.
package sscd_pkg;

  typedef enum logic [1:0] {
    CMD_IDLE = 2'd0,
    CMD_TELL = 2'd1,
    CMD_SEEK = 2'd2,
    CMD_FIRE = 2'd3
  } cmd_t;

  localparam logic [7:0] BAD_COMMAND_REPLY = 8'hEE;
  localparam logic [2:0] PAIR_BYTES        = 3'd4;
  localparam logic [2:0] DURATION_BYTES    = 3'd2;
  localparam logic [15:0] DURATION_RESET   = 16'd2;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        seek_valid;
    logic [15:0] seek_target_one;
    logic [15:0] seek_target_two;
    logic        fire_valid;
    logic [15:0] fire_ticks;
  } result_t;

endpackage

// ===== src/spi_slave_command_deframer_top.sv =====
// SPI slave command deframer: decodes report, seek and fire commands from received bytes.
// Depends on sscd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one received SPI byte per transaction, with
//   both axis positions alongside; the positions are sampled only on a report command.
//   Output channel (out_valid / out_stall): exactly one result per input transaction,
//   carrying tx, seek and fire fields; fields whose valid flag is low read as zero.
//   Each result is registered in the output or, while that is held, the skid register.
//   Throughput: one transaction per cycle while in_stall is low; decode is a single
//   combinational pass from the command state registers into the output or skid register.
//   Stall: a two-entry output (output register plus skid register) lets one more input
//   be accepted while a result is held; in_stall rises only when both are full and
//   drops as soon as the held result is taken.
//   Reset (rst, synchronous): command state returns to idle, byte index to zero, the
//   position buffer to zero, the duration buffer to two, and both output entries empty.
module spi_slave_command_deframer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic signed [15:0] axis_one_position,
  input  logic signed [15:0] axis_two_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               tx_valid,
  output logic [7:0]         tx_byte,
  output logic               seek_valid,
  output logic signed [15:0] seek_target_one,
  output logic signed [15:0] seek_target_two,
  output logic               fire_valid,
  output logic [15:0]        fire_ticks
);

  sscd_pkg::cmd_t    active_command, active_command_next;
  logic [2:0]        byte_index, byte_index_next;
  logic [31:0]       pair_buffer, pair_buffer_next;
  logic [15:0]       duration_buffer, duration_buffer_next;
  sscd_pkg::result_t res;
  sscd_pkg::result_t out_res;
  sscd_pkg::result_t skid_res;
  logic              skid_full;
  logic              accept;
  logic              take;
  logic [1:0]        pos;
  logic [2:0]        pos_inc;

  assign in_stall = skid_full;
  assign accept   = in_valid & ~skid_full;
  assign take     = out_valid & ~out_stall;
  assign pos      = byte_index[1:0];
  assign pos_inc  = {1'b0, pos} + 3'd1;

  always_comb begin
    res                  = '0;
    active_command_next  = active_command;
    byte_index_next      = byte_index;
    pair_buffer_next     = pair_buffer;
    duration_buffer_next = duration_buffer;
    case (active_command)
      sscd_pkg::CMD_TELL: begin
        res.tx_valid    = 1'b1;
        res.tx_byte     = pair_buffer[{pos, 3'b000} +: 8];
        byte_index_next = pos_inc;
        if (pos_inc >= sscd_pkg::PAIR_BYTES) begin
          active_command_next = sscd_pkg::CMD_IDLE;
        end
      end
      sscd_pkg::CMD_SEEK: begin
        pair_buffer_next[{pos, 3'b000} +: 8] = rx_byte;
        byte_index_next = pos_inc;
        if (pos_inc >= sscd_pkg::PAIR_BYTES) begin
          res.seek_valid      = 1'b1;
          res.seek_target_one = pair_buffer_next[15:0];
          res.seek_target_two = pair_buffer_next[31:16];
          active_command_next = sscd_pkg::CMD_IDLE;
        end
      end
      sscd_pkg::CMD_FIRE: begin
        duration_buffer_next[{pos[0], 3'b000} +: 8] = rx_byte;
        byte_index_next = pos_inc;
        if (pos_inc >= sscd_pkg::DURATION_BYTES) begin
          res.fire_valid      = 1'b1;
          res.fire_ticks      = duration_buffer_next;
          active_command_next = sscd_pkg::CMD_IDLE;
        end
      end
      default: begin
        byte_index_next = 3'd0;
        if (rx_byte == {6'd0, sscd_pkg::CMD_TELL}) begin
          active_command_next = sscd_pkg::CMD_TELL;
          pair_buffer_next    = {axis_two_position, axis_one_position};
        end else if (rx_byte == {6'd0, sscd_pkg::CMD_SEEK}) begin
          active_command_next = sscd_pkg::CMD_SEEK;
        end else if (rx_byte == {6'd0, sscd_pkg::CMD_FIRE}) begin
          active_command_next = sscd_pkg::CMD_FIRE;
        end else begin
          active_command_next = sscd_pkg::CMD_IDLE;
          res.tx_valid        = 1'b1;
          res.tx_byte         = sscd_pkg::BAD_COMMAND_REPLY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command  <= sscd_pkg::CMD_IDLE;
      byte_index      <= 3'd0;
      pair_buffer     <= '0;
      duration_buffer <= sscd_pkg::DURATION_RESET;
    end else if (accept) begin
      active_command  <= active_command_next;
      byte_index      <= byte_index_next;
      pair_buffer     <= pair_buffer_next;
      duration_buffer <= duration_buffer_next;
    end
  end

  // Output register plus one skid entry; skid drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_full) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign tx_valid        = out_res.tx_valid;
  assign tx_byte         = out_res.tx_byte;
  assign seek_valid      = out_res.seek_valid;
  assign seek_target_one = out_res.seek_target_one;
  assign seek_target_two = out_res.seek_target_two;
  assign fire_valid      = out_res.fire_valid;
  assign fire_ticks      = out_res.fire_ticks;

endmodule

// ===== src/sscd_checker.sv =====
// Port-level checks for the SPI slave command deframer, bound to its top level.
// Depends on spi_slave_command_deframer_top.
module sscd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic        seek_valid,
  input logic [15:0] seek_target_one,
  input logic        fire_valid,
  input logic [15:0] fire_ticks
);

  // Input side only backs up when a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result held");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({tx_valid, seek_valid, fire_valid}))
    else $error("more than one result kind flagged");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
    else $error("tx_byte nonzero without tx_valid");

  a_seek_fire_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((seek_valid || seek_target_one == 16'd0)
                   && (fire_valid || fire_ticks == 16'd0)))
    else $error("seek or fire field nonzero without its flag");

endmodule

bind spi_slave_command_deframer_top sscd_checker u_sscd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .tx_valid        (tx_valid),
  .tx_byte         (tx_byte),
  .seek_valid      (seek_valid),
  .seek_target_one (seek_target_one),
  .fire_valid      (fire_valid),
  .fire_ticks      (fire_ticks)
);

// ===== sim/tb.sv =====
// Testbench for spi_slave_command_deframer_top: directed and random command streams.
// Checks every result against an in-bench decoder model held in a scoreboard class.
// Depends on sscd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb;

  class deframer_scoreboard;
    sscd_pkg::cmd_t    mode;
    logic [2:0]        byte_pos;
    logic [31:0]       pair_word;
    logic [15:0]       duration_word;
    sscd_pkg::result_t expected_results[$];
    int                fail_count;

    function new();
      mode          = sscd_pkg::CMD_IDLE;
      byte_pos      = 3'd0;
      pair_word     = 32'd0;
      duration_word = sscd_pkg::DURATION_RESET;
      fail_count    = 0;
    endfunction

    // Advance the decoder by one received byte and queue the result it causes.
    function void note_input(logic [7:0] rx, logic [15:0] pos_one, logic [15:0] pos_two);
      sscd_pkg::result_t exp_res;
      logic [1:0]        slot;
      exp_res = '0;
      slot    = byte_pos[1:0];
      case (mode)
        sscd_pkg::CMD_TELL: begin
          exp_res.tx_valid = 1'b1;
          exp_res.tx_byte  = pair_word[slot*8 +: 8];
          byte_pos = {1'b0, slot} + 3'd1;
          if (byte_pos >= sscd_pkg::PAIR_BYTES) mode = sscd_pkg::CMD_IDLE;
        end
        sscd_pkg::CMD_SEEK: begin
          pair_word[slot*8 +: 8] = rx;
          byte_pos = {1'b0, slot} + 3'd1;
          if (byte_pos >= sscd_pkg::PAIR_BYTES) begin
            exp_res.seek_valid      = 1'b1;
            exp_res.seek_target_one = pair_word[15:0];
            exp_res.seek_target_two = pair_word[31:16];
            mode = sscd_pkg::CMD_IDLE;
          end
        end
        sscd_pkg::CMD_FIRE: begin
          duration_word[slot[0]*8 +: 8] = rx;
          byte_pos = {1'b0, slot} + 3'd1;
          if (byte_pos >= sscd_pkg::DURATION_BYTES) begin
            exp_res.fire_valid = 1'b1;
            exp_res.fire_ticks = duration_word;
            mode = sscd_pkg::CMD_IDLE;
          end
        end
        default: begin
          byte_pos = 3'd0;
          if (rx == 8'(sscd_pkg::CMD_TELL)) begin
            mode      = sscd_pkg::CMD_TELL;
            pair_word = {pos_two, pos_one};
          end else if (rx == 8'(sscd_pkg::CMD_SEEK)) begin
            mode = sscd_pkg::CMD_SEEK;
          end else if (rx == 8'(sscd_pkg::CMD_FIRE)) begin
            mode = sscd_pkg::CMD_FIRE;
          end else begin
            mode = sscd_pkg::CMD_IDLE;
            exp_res.tx_valid = 1'b1;
            exp_res.tx_byte  = sscd_pkg::BAD_COMMAND_REPLY;
          end
        end
      endcase
      expected_results.push_back(exp_res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%04h expected 0x%04h", name, got, want));
    endtask

    task check_result(sscd_pkg::result_t got);
      sscd_pkg::result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
        compare_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
        compare_field("seek_valid", 16'(got.seek_valid), 16'(want.seek_valid));
        compare_field("seek_target_one", got.seek_target_one, want.seek_target_one);
        compare_field("seek_target_two", got.seek_target_two, want.seek_target_two);
        compare_field("fire_valid", 16'(got.fire_valid), 16'(want.fire_valid));
        compare_field("fire_ticks", got.fire_ticks, want.fire_ticks);
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic signed [15:0] axis_one_position;
  logic signed [15:0] axis_two_position;
  logic               out_valid;
  logic               out_stall;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               seek_valid;
  logic signed [15:0] seek_target_one;
  logic signed [15:0] seek_target_two;
  logic               fire_valid;
  logic [15:0]        fire_ticks;

  deframer_scoreboard sb;
  int                 send_gap_pct;
  int                 stall_pct;

  spi_slave_command_deframer_top u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .axis_one_position (axis_one_position),
    .axis_two_position (axis_two_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .tx_valid          (tx_valid),
    .tx_byte           (tx_byte),
    .seek_valid        (seek_valid),
    .seek_target_one   (seek_target_one),
    .seek_target_two   (seek_target_two),
    .fire_valid        (fire_valid),
    .fire_ticks        (fire_ticks)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    sscd_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.tx_valid        = tx_valid;
      got.tx_byte         = tx_byte;
      got.seek_valid      = seek_valid;
      got.seek_target_one = seek_target_one;
      got.seek_target_two = seek_target_two;
      got.fire_valid      = fire_valid;
      got.fire_ticks      = fire_ticks;
      sb.check_result(got);
    end
  end

  // One transaction; the payload holds until the deframer takes it.
  task automatic send_byte(logic [7:0] b, logic [15:0] pos_one, logic [15:0] pos_two);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    rx_byte           <= b;
    axis_one_position <= pos_one;
    axis_two_position <= pos_two;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(b, pos_one, pos_two);
  endtask

  task automatic send_random_bytes(int n);
    repeat (n) send_byte(8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_command(sscd_pkg::cmd_t cmd);
    send_byte(8'(cmd), 16'($urandom), 16'($urandom));
  endtask

  // Mostly complete commands with random content, some stray bytes.
  task automatic run_random(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_command(sscd_pkg::CMD_TELL);
        send_random_bytes(4);
        sent += 5;
      end else if (pick < 50) begin
        send_command(sscd_pkg::CMD_SEEK);
        send_random_bytes(4);
        sent += 5;
      end else if (pick < 75) begin
        send_command(sscd_pkg::CMD_FIRE);
        send_random_bytes(2);
        sent += 3;
      end else begin
        send_random_bytes(1);
        sent += 1;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb                = new();
    send_gap_pct      = 0;
    stall_pct         = 0;
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    rx_byte           <= 8'd0;
    axis_one_position <= 16'd0;
    axis_two_position <= 16'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unknown command bytes, zero included
    send_byte(8'h00, 16'h0000, 16'h0000);
    send_byte(8'hFF, 16'hFFFF, 16'hFFFF);
    send_byte(8'h04, 16'h1234, 16'h5678);
    // Report: positions change and command-like bytes arrive while shifting out
    send_byte(8'(sscd_pkg::CMD_TELL), 16'h8000, 16'h7FFF);
    send_byte(8'(sscd_pkg::CMD_SEEK), 16'h0000, 16'h0000);
    send_byte(8'(sscd_pkg::CMD_FIRE), 16'hFFFF, 16'hFFFF);
    send_byte(8'hFF, 16'h0000, 16'h0000);
    send_byte(8'h00, 16'h0000, 16'h0000);
    send_byte(8'(sscd_pkg::CMD_TELL), 16'hFFFF, 16'h0000);
    send_random_bytes(4);
    // Seek to extreme targets
    send_byte(8'(sscd_pkg::CMD_SEEK), 16'h0000, 16'h0000);
    send_byte(8'h00, 16'h0000, 16'h0000);
    send_byte(8'h80, 16'h0000, 16'h0000);
    send_byte(8'hFF, 16'h0000, 16'h0000);
    send_byte(8'h7F, 16'h0000, 16'h0000);
    // Fire with each byte at its extremes
    send_byte(8'(sscd_pkg::CMD_FIRE), 16'h0000, 16'h0000);
    send_byte(8'hFF, 16'h0000, 16'h0000);
    send_byte(8'h00, 16'h0000, 16'h0000);
    send_byte(8'(sscd_pkg::CMD_FIRE), 16'h0000, 16'h0000);
    send_byte(8'h00, 16'h0000, 16'h0000);
    send_byte(8'hFF, 16'h0000, 16'h0000);
    send_byte(sscd_pkg::BAD_COMMAND_REPLY, 16'h0000, 16'h0000);
    run_random(100);
    wait_drained();

    send_gap_pct = 60;
    stall_pct    = 0;
    run_random(110);
    wait_drained();

    send_gap_pct = 0;
    stall_pct    = 60;
    run_random(110);
    wait_drained();

    send_gap_pct = 31;
    stall_pct    = 31;
    run_random(110);
    wait_drained();

    repeat (4) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_results.size()));
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
